FILE: src/acte_pkg.sv
package acte_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int MAX_LAGS_DEF = 32;

   localparam int SAMPLE_W = 32;
   localparam int LAG_W = 5;
   localparam int STATUS_W = 2;
   localparam int LAGS_W = 6;
   localparam int WF_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [LAGS_W-1:0] LAGS_RESET = 6'd32;
   localparam logic [WF_W-1:0] WF_RESET = 4'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_LAGS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WF = 1'b1;

   localparam logic KIND_CORR = 1'b0;
   localparam logic KIND_TAU = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_VAR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   localparam int DIV_W = 64;
   localparam int FRAC_W = 24;
   localparam int C_W = 42;
   localparam int TAU_W = 40;

   localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh80000000;
   localparam logic signed [TAU_W-1:0] TAU_INIT = TAU_W'(32'sd8388608);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MEAN,
      ST_LAG_START,
      ST_PASS,
      ST_DIV_M1,
      ST_DIV_M2,
      ST_DIV_P,
      ST_MUL,
      ST_CORR,
      ST_OUT_RD,
      ST_DIV_R,
      ST_DIV_RHO,
      ST_TAU_CHK,
      ST_RSP_SET,
      ST_RSP_WAIT,
      ST_TAU_SET
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic frac;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: src/acte_req_if.sv
interface acte_req_if;
   logic valid;
   logic ready;
   logic signed [acte_pkg::SAMPLE_W-1:0] sample;
   logic last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

FILE: src/acte_rsp_if.sv
interface acte_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic [acte_pkg::LAG_W-1:0] lag_index;
   logic signed [acte_pkg::SAMPLE_W-1:0] value;
   logic [acte_pkg::STATUS_W-1:0] status;
   logic last_result;

   modport source (output valid, output result_kind, output lag_index, output value,
                   output status, output last_result, input ready);
   modport sink (input valid, input result_kind, input lag_index, input value,
                 input status, input last_result, output ready);
endinterface

FILE: src/acte_sample_ram.sv
module acte_sample_ram #(
   parameter int DEPTH = acte_pkg::MAX_SAMPLES_DEF,
   parameter int WIDTH = acte_pkg::SAMPLE_W,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_a,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

FILE: src/acte_stat_ram.sv
module acte_stat_ram #(
   parameter int DEPTH = acte_pkg::MAX_LAGS_DEF,
   parameter int WIDTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

FILE: src/acte_divider.sv
module acte_divider (
   input  logic                                     clock,
   input  logic                                     reset,
   input  acte_pkg::div_req_type                    req,
   input  logic signed [acte_pkg::DIV_W-1:0]        num,
   input  logic [acte_pkg::DIV_W-1:0]               den,
   output acte_pkg::div_stat_type                   stat,
   output logic signed [acte_pkg::DIV_W-1:0]        quo,
   output logic signed [acte_pkg::SAMPLE_W-1:0]     quo_q24
);

   localparam int DW = acte_pkg::DIV_W;
   localparam int FW = acte_pkg::FRAC_W;
   localparam int DVD_W = DW + FW;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DW:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [DW-1:0] mag;
   logic [DW:0] rem_t;
   logic sat;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      mag = num[DW-1] ? DW'(-num) : DW'(num);
      rem_t = {rem_ff[DW-1:0], dvd_ff[DVD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DVD_W);
         dvd_in = req.frac ? {mag, FW'(0)} : {FW'(0), mag};
         rem_in = '0;
         den_in = den;
         neg_in = num[DW-1];
      end else if (busy_ff) begin
         if (rem_t >= {1'b0, den_ff}) begin
            rem_in = rem_t - {1'b0, den_ff};
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_t;
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      stat.busy = busy_ff;
      stat.done = done_ff;
      quo = neg_ff ? -$signed(dvd_ff[DW-1:0]) : $signed(dvd_ff[DW-1:0]);
      sat = |dvd_ff[DVD_W-1:acte_pkg::SAMPLE_W-1];
      if (sat) begin
         quo_q24 = neg_ff ? acte_pkg::Q_MIN : acte_pkg::Q_MAX;
      end else if (neg_ff) begin
         quo_q24 = -$signed(dvd_ff[acte_pkg::SAMPLE_W-1:0]);
      end else begin
         quo_q24 = $signed(dvd_ff[acte_pkg::SAMPLE_W-1:0]);
      end
   end

endmodule

FILE: src/autocorrelation_tau_estimator.sv
// Autocorrelation and integrated autocorrelation time of a run of samples.
// The req_bus channel carries one signed Q8.24 sample per item; the item
// with last_sample set closes the run. Samples are taken one per cycle and
// written to the sample memory; once the memory is full further samples are
// dropped and every result of the run reports the overflow status.
// After the last sample the block makes one division for the mean and then,
// for each lag k below the sample count n, one pass over the n-k stored pairs
// (two reads of the sample memory per cycle) and three divisions of the shared
// radix-2 divider; a lag k of n or more gets a zero entry.
// It then emits one correlation item per lag on rsp_bus, each taking one or
// two further divisions (none under zero variance), and then the tau item.
// No new sample is taken until the tau item, marked last_result, has been
// taken; a stalled receiver simply holds the block in its output state.
// Reset clears the run count and the overflow flag and sets the lag count
// to 32 and the window factor to 6. The memories need no clearing pass.
// The csr port must be written only while no run is being computed; the
// block itself does not enforce this.
module autocorrelation_tau_estimator #(
   parameter int MAX_SAMPLES = acte_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_LAGS = acte_pkg::MAX_LAGS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   acte_req_if.sink                              req_bus,
   acte_rsp_if.source                            rsp_bus,
   input  logic                                  csr_we,
   input  logic [acte_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [acte_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int KW = $clog2(MAX_LAGS);
   localparam int NW = $clog2(MAX_LAGS + 1);
   localparam int TOT_W = 33 + AW;
   localparam int PW = 40 + AW;
   localparam int SCW = 42 + AW;
   localparam int CW = acte_pkg::C_W;
   localparam int TW = acte_pkg::TAU_W;
   localparam int WW = acte_pkg::WF_W;
   localparam int DW = acte_pkg::DIV_W;
   localparam int XW = acte_pkg::SAMPLE_W;

   acte_pkg::seq_state_type state_ff, state_in;

   logic [acte_pkg::LAGS_W-1:0] lags_cfg_ff;
   logic [WW-1:0] wf_ff;

   logic [CNTW-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic signed [TOT_W-1:0] total_ff, total_in;
   logic [NW-1:0] lags_n_ff, lags_n_in;
   logic [KW-1:0] k_ff, k_in;
   logic [CNTW-1:0] m_ff, m_in, i_ff, i_in;
   logic signed [XW-1:0] mean_ff, mean_in;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [XW-1:0] a2_ff, a2_in, b2_ff, b2_in, h1_ff, h1_in, h2_ff, h2_in;
   logic signed [63:0] pab_ff, pab_in, ph_ff, ph_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic signed [TOT_W-1:0] s1_ff, s1_in, s2_ff, s2_in;
   logic signed [SCW-1:0] sc_ff, sc_in;
   logic signed [XW-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic signed [CW-1:0] pm_ff, pm_in;
   logic signed [63:0] mm_ff, mm_in;
   logic signed [CW-1:0] c0_ff, c0_in;
   logic signed [SCW-1:0] s0_ff, s0_in;
   logic signed [XW-1:0] r_ff, r_in;
   logic signed [TW-1:0] tau_ff, tau_in;
   logic tau_act_ff, tau_act_in;
   logic rho_np_ff, rho_np_in;
   logic div_pend_ff, div_pend_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic [acte_pkg::LAG_W-1:0] rsp_lag_ff, rsp_lag_in;
   logic signed [XW-1:0] rsp_value_ff, rsp_value_in;
   logic [acte_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_ready;
   logic accept;
   logic iss;
   logic sram_we, sram_re;
   logic [AW-1:0] sram_raddr_a, sram_raddr_b;
   logic signed [XW-1:0] ra, rb;
   logic signed [XW:0] da, db;
   logic st_we, st_re;
   logic [CW+SCW-1:0] st_wdata, st_rdata;
   logic signed [CW-1:0] st_c, c_new;
   logic signed [SCW-1:0] st_s;
   logic zv;
   logic lag_last;
   logic [acte_pkg::STATUS_W-1:0] st_code;
   logic signed [TW+WW:0] wprod, lim;
   logic signed [XW-1:0] tau_sat;

   acte_pkg::div_req_type div_req;
   acte_pkg::div_stat_type div_stat;
   logic signed [DW-1:0] div_num, div_quo;
   logic [DW-1:0] div_den;
   logic signed [XW-1:0] div_q24;

   acte_sample_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(XW)) u_sample_ram (
      .clock   (clock),
      .we      (sram_we),
      .waddr   (count_ff[AW-1:0]),
      .wdata   (req_bus.sample),
      .re      (sram_re),
      .raddr_a (sram_raddr_a),
      .raddr_b (sram_raddr_b),
      .rdata_a (ra),
      .rdata_b (rb)
   );

   acte_stat_ram #(.DEPTH(MAX_LAGS), .WIDTH(CW + SCW)) u_stat_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (k_ff),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (k_ff),
      .rdata (st_rdata)
   );

   acte_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .req     (div_req),
      .num     (div_num),
      .den     (div_den),
      .stat    (div_stat),
      .quo     (div_quo),
      .quo_q24 (div_q24)
   );

   assign req_ready = (state_ff == acte_pkg::ST_LOAD);
   assign req_bus.ready = req_ready;
   assign accept = req_bus.valid & req_ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.result_kind = rsp_kind_ff;
   assign rsp_bus.lag_index = rsp_lag_ff;
   assign rsp_bus.value = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.last_result = rsp_last_ff;

   assign st_c = $signed(st_rdata[CW+SCW-1:SCW]);
   assign st_s = $signed(st_rdata[SCW-1:0]);
   assign zv = (c0_ff <= 0) || (s0_ff <= 0);
   assign lag_last = (NW'(k_ff) + NW'(1) == lags_n_ff);
   assign st_code = ovf_ff ? acte_pkg::STATUS_OVERFLOW :
                    (zv ? acte_pkg::STATUS_ZERO_VAR : acte_pkg::STATUS_OK);
   assign da = (XW+1)'(ra) - (XW+1)'(mean_ff);
   assign db = (XW+1)'(rb) - (XW+1)'(mean_ff);
   assign c_new = pm_ff - CW'(mm_ff >>> 24);

   always_comb begin
      wprod = $signed({1'b0, wf_ff}) * tau_ff;
      lim = '0;
      lim[KW+23:24] = k_ff;
      if (tau_ff > TW'(acte_pkg::Q_MAX)) begin
         tau_sat = acte_pkg::Q_MAX;
      end else if (tau_ff < TW'(acte_pkg::Q_MIN)) begin
         tau_sat = acte_pkg::Q_MIN;
      end else begin
         tau_sat = XW'(tau_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      total_in = total_ff;
      lags_n_in = lags_n_ff;
      k_in = k_ff;
      m_in = m_ff;
      i_in = i_ff;
      mean_in = mean_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      pm_in = pm_ff;
      mm_in = mm_ff;
      c0_in = c0_ff;
      s0_in = s0_ff;
      r_in = r_ff;
      tau_in = tau_ff;
      tau_act_in = tau_act_ff;
      rho_np_in = rho_np_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_lag_in = rsp_lag_ff;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = rsp_last_ff;
      sram_we = 1'b0;
      sram_re = 1'b0;
      iss = 1'b0;
      st_we = 1'b0;
      st_re = 1'b0;
      st_wdata = {c_new, sc_ff};
      div_req = '0;
      div_num = '0;
      div_den = '0;
      sram_raddr_a = i_ff[AW-1:0];
      sram_raddr_b = AW'(i_ff + CNTW'(k_ff));

      a2_in = a2_ff;
      b2_in = b2_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      pab_in = pab_ff;
      ph_in = ph_ff;
      p_in = p_ff;
      sc_in = sc_ff;
      if (v1_ff) begin
         a2_in = ra;
         b2_in = rb;
         h1_in = da[XW:1];
         h2_in = db[XW:1];
      end
      if (v2_ff) begin
         s1_in = s1_ff + TOT_W'(a2_ff);
         s2_in = s2_ff + TOT_W'(b2_ff);
         pab_in = a2_ff * b2_ff;
         ph_in = h1_ff * h2_ff;
      end
      if (v3_ff) begin
         p_in = p_ff + PW'(pab_ff >>> 24);
         sc_in = sc_ff + SCW'(ph_ff >>> 22);
      end

      case (state_ff)
         acte_pkg::ST_LOAD: begin
            if (accept) begin
               if (count_ff < CNTW'(MAX_SAMPLES)) begin
                  sram_we = 1'b1;
                  count_in = count_ff + CNTW'(1);
                  total_in = total_ff + TOT_W'(req_bus.sample);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.last_sample) begin
                  if (lags_cfg_ff == '0) begin
                     lags_n_in = NW'(1);
                  end else if (int'(lags_cfg_ff) > MAX_LAGS) begin
                     lags_n_in = NW'(MAX_LAGS);
                  end else begin
                     lags_n_in = NW'(lags_cfg_ff);
                  end
                  state_in = acte_pkg::ST_MEAN;
               end
            end
         end
         acte_pkg::ST_MEAN: begin
            div_req.start = ~div_pend_ff;
            div_num = DW'(total_ff);
            div_den = DW'(count_ff);
            if (div_stat.done) begin
               mean_in = XW'(div_quo);
               k_in = '0;
               state_in = acte_pkg::ST_LAG_START;
            end
         end
         acte_pkg::ST_LAG_START: begin
            if (CNTW'(k_ff) >= count_ff) begin
               st_we = 1'b1;
               st_wdata = '0;
               if (lag_last) begin
                  k_in = '0;
                  tau_in = acte_pkg::TAU_INIT;
                  tau_act_in = 1'b1;
                  state_in = acte_pkg::ST_OUT_RD;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end else begin
               m_in = count_ff - CNTW'(k_ff);
               i_in = '0;
               p_in = '0;
               s1_in = '0;
               s2_in = '0;
               sc_in = '0;
               state_in = acte_pkg::ST_PASS;
            end
         end
         acte_pkg::ST_PASS: begin
            if (i_ff < m_ff) begin
               iss = 1'b1;
               sram_re = 1'b1;
               i_in = i_ff + CNTW'(1);
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = acte_pkg::ST_DIV_M1;
            end
         end
         acte_pkg::ST_DIV_M1: begin
            div_req.start = ~div_pend_ff;
            div_num = DW'(s1_ff);
            div_den = DW'(m_ff);
            if (div_stat.done) begin
               m1_in = XW'(div_quo);
               state_in = acte_pkg::ST_DIV_M2;
            end
         end
         acte_pkg::ST_DIV_M2: begin
            div_req.start = ~div_pend_ff;
            div_num = DW'(s2_ff);
            div_den = DW'(m_ff);
            if (div_stat.done) begin
               m2_in = XW'(div_quo);
               state_in = acte_pkg::ST_DIV_P;
            end
         end
         acte_pkg::ST_DIV_P: begin
            div_req.start = ~div_pend_ff;
            div_num = DW'(p_ff);
            div_den = DW'(m_ff);
            if (div_stat.done) begin
               pm_in = CW'(div_quo);
               state_in = acte_pkg::ST_MUL;
            end
         end
         acte_pkg::ST_MUL: begin
            mm_in = m1_ff * m2_ff;
            state_in = acte_pkg::ST_CORR;
         end
         acte_pkg::ST_CORR: begin
            st_we = 1'b1;
            if (k_ff == '0) begin
               c0_in = c_new;
               s0_in = sc_ff;
            end
            if (lag_last) begin
               k_in = '0;
               tau_in = acte_pkg::TAU_INIT;
               tau_act_in = 1'b1;
               state_in = acte_pkg::ST_OUT_RD;
            end else begin
               k_in = k_ff + KW'(1);
               state_in = acte_pkg::ST_LAG_START;
            end
         end
         acte_pkg::ST_OUT_RD: begin
            st_re = 1'b1;
            state_in = acte_pkg::ST_DIV_R;
         end
         acte_pkg::ST_DIV_R: begin
            if (zv) begin
               r_in = '0;
               state_in = acte_pkg::ST_RSP_SET;
            end else begin
               div_req.start = ~div_pend_ff;
               div_req.frac = 1'b1;
               div_num = DW'(st_c);
               div_den = DW'(c0_ff);
               if (div_stat.done) begin
                  r_in = div_q24;
                  if (tau_act_ff && (k_ff != '0)) begin
                     state_in = acte_pkg::ST_DIV_RHO;
                  end else begin
                     state_in = acte_pkg::ST_RSP_SET;
                  end
               end
            end
         end
         acte_pkg::ST_DIV_RHO: begin
            div_req.start = ~div_pend_ff;
            div_req.frac = 1'b1;
            div_num = DW'(st_s);
            div_den = DW'(s0_ff);
            if (div_stat.done) begin
               tau_in = tau_ff + TW'(div_q24);
               rho_np_in = (div_q24 <= 0);
               state_in = acte_pkg::ST_TAU_CHK;
            end
         end
         acte_pkg::ST_TAU_CHK: begin
            if (rho_np_ff || (wprod < lim)) begin
               tau_act_in = 1'b0;
            end
            state_in = acte_pkg::ST_RSP_SET;
         end
         acte_pkg::ST_RSP_SET: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = acte_pkg::KIND_CORR;
            rsp_lag_in = acte_pkg::LAG_W'(k_ff);
            rsp_value_in = r_ff;
            rsp_status_in = st_code;
            rsp_last_in = 1'b0;
            state_in = acte_pkg::ST_RSP_WAIT;
         end
         acte_pkg::ST_RSP_WAIT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in = 1'b0;
                  total_in = '0;
                  state_in = acte_pkg::ST_LOAD;
               end else if (lag_last) begin
                  state_in = acte_pkg::ST_TAU_SET;
               end else begin
                  k_in = k_ff + KW'(1);
                  state_in = acte_pkg::ST_OUT_RD;
               end
            end
         end
         acte_pkg::ST_TAU_SET: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = acte_pkg::KIND_TAU;
            rsp_lag_in = '0;
            rsp_value_in = tau_sat;
            rsp_status_in = st_code;
            rsp_last_in = 1'b1;
            state_in = acte_pkg::ST_RSP_WAIT;
         end
         default: begin
            state_in = acte_pkg::ST_LOAD;
         end
      endcase

      v1_in = iss;
      v2_in = v1_ff;
      v3_in = v2_ff;
      div_pend_in = div_pend_ff;
      if (div_req.start) begin
         div_pend_in = 1'b1;
      end else if (div_stat.done) begin
         div_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acte_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lags_cfg_ff <= acte_pkg::LAGS_RESET;
         wf_ff <= acte_pkg::WF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            acte_pkg::CSR_LAGS: lags_cfg_ff <= csr_wdata;
            acte_pkg::CSR_WF: wf_ff <= csr_wdata[WW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         total_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         div_pend_ff <= 1'b0;
         tau_act_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         total_ff <= total_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         div_pend_ff <= div_pend_in;
         tau_act_ff <= tau_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lags_n_ff <= lags_n_in;
      k_ff <= k_in;
      m_ff <= m_in;
      i_ff <= i_in;
      mean_ff <= mean_in;
      a2_ff <= a2_in;
      b2_ff <= b2_in;
      h1_ff <= h1_in;
      h2_ff <= h2_in;
      pab_ff <= pab_in;
      ph_ff <= ph_in;
      p_ff <= p_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      sc_ff <= sc_in;
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      pm_ff <= pm_in;
      mm_ff <= mm_in;
      c0_ff <= c0_in;
      s0_ff <= s0_in;
      r_ff <= r_in;
      tau_ff <= tau_in;
      rho_np_ff <= rho_np_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_lag_ff <= rsp_lag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("Input ready while a result item is pending.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SAMPLES))
      else $error("Sample count beyond the store depth.");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy && !div_pend_ff)
      else $error("Divider started while busy.");

   a_last_is_tau: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff == acte_pkg::KIND_TAU))
      else $error("Last result item is not the tau item.");

endmodule

FILE: verif/tb_autocorrelation_tau_estimator.sv
`timescale 1ns / 1ps

module tb_autocorrelation_tau_estimator;

   localparam int STORE_DEPTH = acte_pkg::MAX_SAMPLES_DEF;
   localparam int LAG_DEPTH = acte_pkg::MAX_LAGS_DEF;
   localparam longint CYCLE_LIMIT = 10000000;
   localparam int CALM_FROM = 30000;
   localparam int CALM_TO = 90000;
   localparam int HOLD_CYCLES = 2500;

   localparam int GEN_FULL = 0;
   localparam int GEN_WALK = 1;
   localparam int GEN_CONST = 2;
   localparam int GEN_ALT = 3;
   localparam int GEN_NOISE = 4;

   typedef struct {
      logic signed [acte_pkg::SAMPLE_W-1:0] sample;
      logic last_sample;
   } sample_item_type;

   typedef struct {
      logic result_kind;
      logic [acte_pkg::LAG_W-1:0] lag_index;
      logic signed [acte_pkg::SAMPLE_W-1:0] value;
      logic [acte_pkg::STATUS_W-1:0] status;
      logic last_result;
   } estimate_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [acte_pkg::CSR_IDX_W-1:0] csr_index;
   logic [acte_pkg::CSR_DATA_W-1:0] csr_wdata;

   acte_req_if req_bus();
   acte_rsp_if rsp_bus();

   autocorrelation_tau_estimator dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   sample_item_type pending_samples[$];
   estimate_type expected_estimates[$];

   logic [acte_pkg::LAGS_W-1:0] lags_setting;
   logic [acte_pkg::WF_W-1:0] window_setting;
   logic signed [acte_pkg::SAMPLE_W-1:0] run_store[STORE_DEPTH];
   int unsigned run_count;
   bit run_overflow;

   longint cycle_count;
   int error_count;
   bit hold_request;
   bit hold_seen;
   int hold_left;
   bit calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic logic signed [acte_pkg::SAMPLE_W-1:0] q24_ratio(longint num,
                                                                     longint den);
      logic [127:0] a;
      logic [127:0] d;
      logic [127:0] q;
      longint mag;
      bit neg;
      neg = num < 0;
      mag = neg ? -num : num;
      a = {64'd0, mag};
      d = {64'd0, den};
      if (a / d >= 128)
         return neg ? acte_pkg::Q_MIN : acte_pkg::Q_MAX;
      q = (a << acte_pkg::FRAC_W) / d;
      return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
   endfunction

   task automatic estimate_run();
      longint c[LAG_DEPTH];
      longint s[LAG_DEPTH];
      longint rho[LAG_DEPTH];
      longint p, s1, s2, m1, m2, a, b, total, mean, h1, h2, tau;
      int unsigned n, lags, m, span;
      bit zerovar;
      logic [acte_pkg::STATUS_W-1:0] st;
      estimate_type e;
      n = run_count;
      lags = lags_setting;
      if (lags < 1) lags = 1;
      if (lags > LAG_DEPTH) lags = LAG_DEPTH;
      for (int k = 0; k < lags; k++) begin
         c[k] = 0;
         if (k < n) begin
            m = n - k;
            p = 0;
            s1 = 0;
            s2 = 0;
            for (int i = 0; i < m; i++) begin
               a = run_store[i];
               b = run_store[i + k];
               p += (a * b) >>> 24;
               s1 += a;
               s2 += b;
            end
            m1 = s1 / longint'(m);
            m2 = s2 / longint'(m);
            c[k] = p / longint'(m) - ((m1 * m2) >>> 24);
         end
      end
      total = 0;
      for (int i = 0; i < n; i++) total += run_store[i];
      mean = total / longint'(n);
      for (int k = 0; k < lags; k++) begin
         s[k] = 0;
         for (int i = 0; i + k < n; i++) begin
            h1 = (longint'(run_store[i]) - mean) >>> 1;
            h2 = (longint'(run_store[i + k]) - mean) >>> 1;
            s[k] += (h1 * h2) >>> 22;
         end
      end
      zerovar = c[0] <= 0 || s[0] <= 0;
      st = run_overflow ? acte_pkg::STATUS_OVERFLOW :
           (zerovar ? acte_pkg::STATUS_ZERO_VAR : acte_pkg::STATUS_OK);
      for (int k = 0; k < lags; k++) begin
         e.result_kind = acte_pkg::KIND_CORR;
         e.lag_index = acte_pkg::LAG_W'(k);
         e.value = zerovar ? '0 : q24_ratio(c[k], c[0]);
         e.status = st;
         e.last_result = 1'b0;
         expected_estimates.push_back(e);
      end
      tau = longint'(1) << 23;
      if (!zerovar) begin
         span = lags;
         for (int k = 0; k < lags; k++) begin
            rho[k] = q24_ratio(s[k], s[0]);
            if (rho[k] <= 0) begin
               span = k + 1;
               break;
            end
         end
         for (int k = 1; k < span; k++) begin
            tau += rho[k];
            if (longint'(window_setting) * tau < (longint'(k) << 24)) break;
         end
      end
      e.result_kind = acte_pkg::KIND_TAU;
      e.lag_index = '0;
      e.value = tau > longint'(acte_pkg::Q_MAX) ? acte_pkg::Q_MAX :
                (tau < longint'(acte_pkg::Q_MIN) ? acte_pkg::Q_MIN : tau[31:0]);
      e.status = st;
      e.last_result = 1'b1;
      expected_estimates.push_back(e);
      run_count = 0;
      run_overflow = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_autocorrelation_tau_estimator NOT OK");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      calm = cycle_count >= CALM_FROM && cycle_count < CALM_TO;
   end

   always @(posedge clock) begin
      sample_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
            it = pending_samples.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.sample <= it.sample;
            req_bus.last_sample <= it.last_sample;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (run_count < STORE_DEPTH) begin
            run_store[run_count] = req_bus.sample;
            run_count++;
         end else begin
            run_overflow = 1'b1;
         end
         if (req_bus.last_sample) estimate_run();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || $urandom_range(99) >= 13;
      end
   end

   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_estimates.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            e = expected_estimates.pop_front();
            if (rsp_bus.result_kind !== e.result_kind)
               report_mismatch($sformatf("result_kind %0b, expected %0b",
                                         rsp_bus.result_kind, e.result_kind));
            if (rsp_bus.lag_index !== e.lag_index)
               report_mismatch($sformatf("lag_index %0d, expected %0d",
                                         rsp_bus.lag_index, e.lag_index));
            if (rsp_bus.value !== e.value)
               report_mismatch($sformatf("value %h, expected %h at lag %0d",
                                         rsp_bus.value, e.value, e.lag_index));
            if (rsp_bus.status !== e.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_bus.status, e.status));
            if (rsp_bus.last_result !== e.last_result)
               report_mismatch($sformatf("last_result %0b, expected %0b",
                                         rsp_bus.last_result, e.last_result));
         end
      end
   end

   task automatic write_csr(input logic [acte_pkg::CSR_IDX_W-1:0] idx,
                            input logic [acte_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == acte_pkg::CSR_LAGS)
         lags_setting = data[acte_pkg::LAGS_W-1:0];
      else
         window_setting = data[acte_pkg::WF_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || expected_estimates.size() != 0);
      repeat (400) @(posedge clock);
   endtask

   task automatic queue_run(input int n, input int shape);
      sample_item_type it;
      int signed v;
      int signed big;
      v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      big = int'($urandom_range(1, 32'h7FFFFFFF));
      if (shape == GEN_CONST) v = $urandom;
      for (int i = 0; i < n; i++) begin
         case (shape)
            GEN_FULL: v = $urandom;
            GEN_WALK: v = v + int'($urandom_range(0, 1 << 23)) - (1 << 22);
            GEN_ALT: v = (i % 2) ? big : -big;
            GEN_NOISE: v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            default: ;
         endcase
         it.sample = v;
         it.last_sample = i == n - 1;
         pending_samples.push_back(it);
      end
   endtask

   task automatic queue_fixed(input logic signed [acte_pkg::SAMPLE_W-1:0] vals[$]);
      sample_item_type it;
      foreach (vals[i]) begin
         it.sample = vals[i];
         it.last_sample = i == vals.size() - 1;
         pending_samples.push_back(it);
      end
   endtask

   initial begin
      int random_items;
      int n;
      int runs;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.last_sample = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = acte_pkg::CSR_LAGS;
      csr_wdata = '0;
      lags_setting = acte_pkg::LAGS_RESET;
      window_setting = acte_pkg::WF_RESET;
      run_count = 0;
      run_overflow = 1'b0;
      error_count = 0;
      hold_request = 1'b0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset settings: constant run, single sample, extremes, smooth walk.
      queue_run(5, GEN_CONST);
      queue_fixed('{32'sh12345678});
      queue_fixed('{acte_pkg::Q_MAX, acte_pkg::Q_MIN, acte_pkg::Q_MAX, acte_pkg::Q_MIN,
                    32'sd0, -32'sd1});
      queue_run(12, GEN_WALK);
      settle();

      write_csr(acte_pkg::CSR_LAGS, 6'd0);
      write_csr(acte_pkg::CSR_WF, 6'd0);
      queue_run(10, GEN_WALK);
      settle();

      // The store fills and the remaining samples of the run are dropped.
      write_csr(acte_pkg::CSR_LAGS, 6'd1);
      write_csr(acte_pkg::CSR_WF, 6'd15);
      queue_run(STORE_DEPTH + 4, GEN_FULL);
      settle();

      // Two runs queued together while the receiver holds off.
      write_csr(acte_pkg::CSR_LAGS, 6'd63);
      write_csr(acte_pkg::CSR_WF, 6'd1);
      queue_run(6, GEN_ALT);
      queue_run(8, GEN_NOISE);
      @(negedge clock);
      hold_request = 1'b1;
      settle();

      random_items = 0;
      while (random_items < 180) begin
         case ($urandom_range(9))
            0: write_csr(acte_pkg::CSR_LAGS, acte_pkg::CSR_DATA_W'($urandom_range(33, 63)));
            1: write_csr(acte_pkg::CSR_LAGS, 6'd32);
            default: write_csr(acte_pkg::CSR_LAGS,
                               acte_pkg::CSR_DATA_W'($urandom_range(0, 8)));
         endcase
         write_csr(acte_pkg::CSR_WF, acte_pkg::CSR_DATA_W'($urandom_range(0, 15)));
         runs = $urandom_range(1, 3);
         for (int r = 0; r < runs; r++) begin
            n = $urandom_range(1, 24);
            case ($urandom_range(9))
               0: queue_run(n, GEN_CONST);
               1: queue_run(n, GEN_ALT);
               2, 3: queue_run(n, GEN_FULL);
               4, 5: queue_run(n, GEN_NOISE);
               default: queue_run(n, GEN_WALK);
            endcase
            random_items += n;
         end
         settle();
      end

      if (error_count == 0)
         $display("tb_autocorrelation_tau_estimator OK");
      else
         $display("tb_autocorrelation_tau_estimator NOT OK");
      $finish;
   end

endmodule
